@@ design/nested_region_peak_tracker_defines.svh @@
// Assertion macros shared by the nested region peak tracker RTL.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef NESTED_REGION_PEAK_TRACKER_DEFINES_SVH
`define NESTED_REGION_PEAK_TRACKER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define NRPT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define NRPT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/nrpt_pkg.sv @@
// Types, sizes and codes for the nested region peak tracker.
// No dependencies; used by every other file of the block but the defines header.
package nrpt_pkg;

  localparam int MAX_STAMPS = 64;
  localparam int SIZE_BITS  = 48;
  localparam int IDX_W      = $clog2(MAX_STAMPS);
  localparam int CNT_W      = $clog2(MAX_STAMPS + 1);
  localparam int DELTA_W    = SIZE_BITS + 1;
  // running sum of up to MAX_STAMPS deltas plus one interval peak
  localparam int ACC_W      = SIZE_BITS + IDX_W + 2;

  typedef logic [SIZE_BITS-1:0]      sz_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CNT_W-1:0]          cnt_t;

  localparam logic OP_OPEN  = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_FULL     = 2'd1;
  localparam logic [1:0] ERR_NONE_OPN = 2'd2;

  localparam cnt_t MAX_CNT = cnt_t'(MAX_STAMPS);

  typedef struct packed {
    logic en;
    idx_t addr;
    sz_t  data;
  } stamp_wr_t;

  typedef struct packed {
    logic   en;
    idx_t   addr;
    sz_t    peak;
    delta_t delta;
  } ivl_wr_t;

endpackage

@@ design/nrpt_in_if.sv @@
// Request channel of the nested region peak tracker.
// Depends on nrpt_pkg.
interface nrpt_in_if;
  logic                valid;
  logic                ready;
  logic                opcode;
  nrpt_pkg::sz_t       peak_sample;
  nrpt_pkg::sz_t       current_sample;
  nrpt_pkg::idx_t      start_index;

  modport source (output valid, opcode, peak_sample, current_sample, start_index,
                  input ready);
  modport sink   (input valid, opcode, peak_sample, current_sample, start_index,
                  output ready);
endinterface

@@ design/nrpt_out_if.sv @@
// Result channel of the nested region peak tracker.
// Depends on nrpt_pkg.
interface nrpt_out_if;
  logic                 valid;
  logic                 ready;
  nrpt_pkg::idx_t       stamp_index;
  nrpt_pkg::sz_t        filler_size;
  nrpt_pkg::sz_t        region_peak;
  nrpt_pkg::delta_t     region_delta;
  logic [1:0]           error;

  modport source (output valid, stamp_index, filler_size, region_peak, region_delta, error,
                  input ready);
  modport sink   (input valid, stamp_index, filler_size, region_peak, region_delta, error,
                  output ready);
endinterface

@@ design/nrpt_acc.sv @@
// Shared add/compare unit: running sum plus peak, max tracking, sum update.
// Depends on nrpt_pkg.
module nrpt_acc (
  input  nrpt_pkg::acc_t sum_in,
  input  nrpt_pkg::acc_t best_in,
  input  nrpt_pkg::acc_t add_pk,
  input  nrpt_pkg::acc_t add_dl,
  output nrpt_pkg::acc_t sum_out,
  output nrpt_pkg::acc_t best_out
);

  nrpt_pkg::acc_t pk_sum;

  assign pk_sum   = sum_in + add_pk;
  assign best_out = (pk_sum > best_in) ? pk_sum : best_in;
  assign sum_out  = sum_in + add_dl;

endmodule

@@ design/nrpt_store.sv @@
// Stamp and interval memories, one write and one registered read each.
// Depends on nrpt_pkg.
module nrpt_store (
  input  logic                clk,
  input  nrpt_pkg::stamp_wr_t stamp_wr,
  input  nrpt_pkg::idx_t      stamp_raddr,
  output nrpt_pkg::sz_t       stamp_rdata,
  input  nrpt_pkg::ivl_wr_t   ivl_wr,
  input  nrpt_pkg::idx_t      ivl_raddr,
  output nrpt_pkg::sz_t       ivl_rpeak,
  output nrpt_pkg::delta_t    ivl_rdelta
);

  nrpt_pkg::sz_t    stamp_mem [nrpt_pkg::MAX_STAMPS];
  nrpt_pkg::sz_t    ipeak_mem [nrpt_pkg::MAX_STAMPS];
  nrpt_pkg::delta_t idelta_mem[nrpt_pkg::MAX_STAMPS];

  always_ff @(posedge clk) begin
    if (stamp_wr.en) begin
      stamp_mem[stamp_wr.addr] <= stamp_wr.data;
    end
    stamp_rdata <= stamp_mem[stamp_raddr];
  end

  always_ff @(posedge clk) begin
    if (ivl_wr.en) begin
      ipeak_mem[ivl_wr.addr]  <= ivl_wr.peak;
      idelta_mem[ivl_wr.addr] <= ivl_wr.delta;
    end
    ivl_rpeak  <= ipeak_mem[ivl_raddr];
    ivl_rdelta <= idelta_mem[ivl_raddr];
  end

endmodule

@@ design/nested_region_peak_tracker.sv @@
// Open: the request is recorded (REC), then staged (DONE) and loaded into the result register;
// close: REC, then WALK reads the intervals from start_index on, one per cycle, then DONE.
// One request in flight at a time; ready again once the result is registered.
// Errors go straight to DONE. Synchronous active-low reset zeroes the counts and control;
// the memories are not cleared (no clearing pass).
// Depends on nrpt_pkg, nrpt_in_if, nrpt_out_if, nrpt_acc, nrpt_store and the defines header.
`include "nested_region_peak_tracker_defines.svh"

module nested_region_peak_tracker (
  input  logic clk,
  input  logic rst_n,
  nrpt_in_if.sink    in_chan,
  nrpt_out_if.source out_chan
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_REC  = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;

  localparam nrpt_pkg::acc_t SAT_HI = nrpt_pkg::acc_t'({nrpt_pkg::SIZE_BITS{1'b1}});
  localparam nrpt_pkg::acc_t SAT_LO = ~SAT_HI;

  logic [2:0]       state_r, state_nxt;
  logic             op_r, op_nxt;
  nrpt_pkg::sz_t    peak_r, peak_nxt;
  nrpt_pkg::sz_t    cur_r, cur_nxt;
  nrpt_pkg::cnt_t   walk_idx_r, walk_idx_nxt;
  logic             pend_r, pend_nxt;
  nrpt_pkg::acc_t   sum_r, sum_nxt;
  nrpt_pkg::acc_t   best_r, best_nxt;
  nrpt_pkg::cnt_t   stamp_cnt_r, stamp_cnt_nxt;
  nrpt_pkg::cnt_t   ivl_cnt_r, ivl_cnt_nxt;
  nrpt_pkg::cnt_t   open_cnt_r, open_cnt_nxt;

  nrpt_pkg::idx_t   res_idx_r, res_idx_nxt;
  nrpt_pkg::sz_t    res_fill_r, res_fill_nxt;
  nrpt_pkg::sz_t    res_peak_r, res_peak_nxt;
  nrpt_pkg::delta_t res_delta_r, res_delta_nxt;
  logic [1:0]       res_err_r, res_err_nxt;

  logic             out_valid_r, out_valid_nxt;
  nrpt_pkg::idx_t   out_idx_r;
  nrpt_pkg::sz_t    out_fill_r;
  nrpt_pkg::sz_t    out_peak_r;
  nrpt_pkg::delta_t out_delta_r;
  logic [1:0]       out_err_r;

  nrpt_pkg::stamp_wr_t stamp_wr;
  nrpt_pkg::ivl_wr_t   ivl_wr;
  nrpt_pkg::sz_t       stamp_rdata;
  nrpt_pkg::sz_t       ivl_rpeak;
  nrpt_pkg::delta_t    ivl_rdelta;

  nrpt_pkg::acc_t   u_sum_in, u_best_in, u_pk, u_dl, u_sum_out, u_best_out;

  logic             in_acc;
  logic             out_load;
  logic             walk_issue;
  nrpt_pkg::sz_t    eff_peak;
  nrpt_pkg::acc_t   sum_sat;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_load      = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);
  assign walk_issue    = (state_r == ST_WALK) && (walk_idx_r < ivl_cnt_r);
  assign eff_peak      = (in_chan.current_sample > in_chan.peak_sample) ?
                         in_chan.current_sample : in_chan.peak_sample;

  assign sum_sat = (sum_r > SAT_HI) ? SAT_HI : ((sum_r < SAT_LO) ? SAT_LO : sum_r);

  // Record mode loads -last as the sum so the unit gives clamp(peak-last) and cur-last.
  always_comb begin
    if (state_r == ST_REC) begin
      u_sum_in  = -nrpt_pkg::acc_t'(stamp_rdata);
      u_best_in = '0;
      u_pk      = nrpt_pkg::acc_t'(peak_r);
      u_dl      = nrpt_pkg::acc_t'(cur_r);
    end else begin
      u_sum_in  = sum_r;
      u_best_in = best_r;
      u_pk      = nrpt_pkg::acc_t'(ivl_rpeak);
      u_dl      = nrpt_pkg::acc_t'(ivl_rdelta);
    end
  end

  nrpt_acc u_acc (
    .sum_in   (u_sum_in),
    .best_in  (u_best_in),
    .add_pk   (u_pk),
    .add_dl   (u_dl),
    .sum_out  (u_sum_out),
    .best_out (u_best_out)
  );

  nrpt_store u_store (
    .clk         (clk),
    .stamp_wr    (stamp_wr),
    .stamp_raddr (nrpt_pkg::idx_t'(stamp_cnt_r - nrpt_pkg::cnt_t'(1))),
    .stamp_rdata (stamp_rdata),
    .ivl_wr      (ivl_wr),
    .ivl_raddr   (walk_idx_r[nrpt_pkg::IDX_W-1:0]),
    .ivl_rpeak   (ivl_rpeak),
    .ivl_rdelta  (ivl_rdelta)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    peak_nxt      = peak_r;
    cur_nxt       = cur_r;
    walk_idx_nxt  = walk_idx_r;
    pend_nxt      = 1'b0;
    sum_nxt       = sum_r;
    best_nxt      = best_r;
    stamp_cnt_nxt = stamp_cnt_r;
    ivl_cnt_nxt   = ivl_cnt_r;
    open_cnt_nxt  = open_cnt_r;
    res_idx_nxt   = res_idx_r;
    res_fill_nxt  = res_fill_r;
    res_peak_nxt  = res_peak_r;
    res_delta_nxt = res_delta_r;
    res_err_nxt   = res_err_r;
    stamp_wr      = '0;
    ivl_wr        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt        = in_chan.opcode;
          peak_nxt      = eff_peak;
          cur_nxt       = in_chan.current_sample;
          walk_idx_nxt  = nrpt_pkg::cnt_t'(in_chan.start_index);
          res_idx_nxt   = '0;
          res_fill_nxt  = '0;
          res_peak_nxt  = '0;
          res_delta_nxt = '0;
          res_err_nxt   = nrpt_pkg::ERR_OK;
          state_nxt     = ST_REC;
          if (in_chan.opcode == nrpt_pkg::OP_OPEN) begin
            if (stamp_cnt_r >= nrpt_pkg::MAX_CNT ||
                (stamp_cnt_r != '0 && ivl_cnt_r >= nrpt_pkg::MAX_CNT)) begin
              res_err_nxt = nrpt_pkg::ERR_FULL;
              state_nxt   = ST_DONE;
            end
          end else if (open_cnt_r == '0) begin
            res_err_nxt = nrpt_pkg::ERR_NONE_OPN;
            state_nxt   = ST_DONE;
          end else if (stamp_cnt_r == '0 || ivl_cnt_r >= nrpt_pkg::MAX_CNT) begin
            res_err_nxt = nrpt_pkg::ERR_FULL;
            state_nxt   = ST_DONE;
          end
        end
      end
      ST_REC: begin
        // an open with no stamp yet records no interval
        if (op_r == nrpt_pkg::OP_CLOSE || stamp_cnt_r != '0) begin
          ivl_wr.en    = 1'b1;
          ivl_wr.addr  = ivl_cnt_r[nrpt_pkg::IDX_W-1:0];
          ivl_wr.peak  = u_best_out[nrpt_pkg::SIZE_BITS-1:0];
          ivl_wr.delta = u_sum_out[nrpt_pkg::DELTA_W-1:0];
          ivl_cnt_nxt  = ivl_cnt_r + nrpt_pkg::cnt_t'(1);
        end
        if (op_r == nrpt_pkg::OP_OPEN) begin
          stamp_wr.en   = 1'b1;
          stamp_wr.addr = stamp_cnt_r[nrpt_pkg::IDX_W-1:0];
          stamp_wr.data = peak_r;
          stamp_cnt_nxt = stamp_cnt_r + nrpt_pkg::cnt_t'(1);
          open_cnt_nxt  = open_cnt_r + nrpt_pkg::cnt_t'(1);
          res_idx_nxt   = stamp_cnt_r[nrpt_pkg::IDX_W-1:0];
          res_fill_nxt  = peak_r - cur_r;
          state_nxt     = ST_DONE;
        end else begin
          open_cnt_nxt = open_cnt_r - nrpt_pkg::cnt_t'(1);
          sum_nxt      = '0;
          best_nxt     = '0;
          state_nxt    = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_issue) begin
          walk_idx_nxt = walk_idx_r + nrpt_pkg::cnt_t'(1);
        end
        pend_nxt = walk_issue;
        if (pend_r) begin
          sum_nxt  = u_sum_out;
          best_nxt = u_best_out;
        end
        if (!walk_issue && !pend_r) begin
          res_peak_nxt  = (best_r > SAT_HI) ? {nrpt_pkg::SIZE_BITS{1'b1}} :
                          best_r[nrpt_pkg::SIZE_BITS-1:0];
          res_delta_nxt = sum_sat[nrpt_pkg::DELTA_W-1:0];
          if (open_cnt_r == '0) begin
            stamp_cnt_nxt = '0;
            ivl_cnt_nxt   = '0;
          end else begin
            ivl_cnt_nxt = ivl_cnt_r - nrpt_pkg::cnt_t'(1);
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      stamp_cnt_r <= '0;
      ivl_cnt_r   <= '0;
      open_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      stamp_cnt_r <= stamp_cnt_nxt;
      ivl_cnt_r   <= ivl_cnt_nxt;
      open_cnt_r  <= open_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    peak_r      <= peak_nxt;
    cur_r       <= cur_nxt;
    walk_idx_r  <= walk_idx_nxt;
    sum_r       <= sum_nxt;
    best_r      <= best_nxt;
    res_idx_r   <= res_idx_nxt;
    res_fill_r  <= res_fill_nxt;
    res_peak_r  <= res_peak_nxt;
    res_delta_r <= res_delta_nxt;
    res_err_r   <= res_err_nxt;
    if (out_load) begin
      out_idx_r   <= res_idx_r;
      out_fill_r  <= res_fill_r;
      out_peak_r  <= res_peak_r;
      out_delta_r <= res_delta_r;
      out_err_r   <= res_err_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.stamp_index  = out_idx_r;
  assign out_chan.filler_size  = out_fill_r;
  assign out_chan.region_peak  = out_peak_r;
  assign out_chan.region_delta = out_delta_r;
  assign out_chan.error        = out_err_r;

  `NRPT_ASSERT_IMP(a_open_le_stamp, 1'b1, open_cnt_r <= stamp_cnt_r,
                   "more regions open than stamps")
  `NRPT_ASSERT_IMP(a_ivl_tracks_stamp, state_r == ST_IDLE && stamp_cnt_r != '0,
                   ivl_cnt_r == stamp_cnt_r - nrpt_pkg::cnt_t'(1),
                   "interval count out of step with stamps")
  `NRPT_ASSERT_IMP(a_idle_no_pend, state_r == ST_IDLE,
                   !pend_r && (ivl_cnt_r == '0 || stamp_cnt_r != '0),
                   "walk read left pending")
  `NRPT_ASSERT_NXT(a_busy_after_req, in_acc, !in_chan.ready,
                   "ready while a request is in flight")

endmodule

@@ bench/tb_nested_region_peak_tracker.sv @@
// Self-checking bench for nested_region_peak_tracker: directed region requests, then randomised
// nesting traffic, checked against an in-bench predictor of stamps, intervals and open regions.
// Depends on nrpt_pkg, nrpt_in_if, nrpt_out_if and the block's RTL.
module tb_nested_region_peak_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     HOLD_CYCLES    = 300;
  localparam int     DRAIN_CYCLES   = 100;
  localparam longint SIZE_HI        = (longint'(1) <<< nrpt_pkg::SIZE_BITS) - 1;
  localparam longint SIZE_LO        = -SIZE_HI - 1;
  localparam nrpt_pkg::sz_t SZ_MAX  = '1;

  typedef struct packed {
    logic           opcode;
    nrpt_pkg::sz_t  peak;
    nrpt_pkg::sz_t  cur;
    nrpt_pkg::idx_t start;
  } region_req_t;

  typedef struct packed {
    nrpt_pkg::idx_t   stamp_index;
    nrpt_pkg::sz_t    filler_size;
    nrpt_pkg::sz_t    region_peak;
    nrpt_pkg::delta_t region_delta;
    logic [1:0]       error;
  } region_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nrpt_in_if  in_chan ();
  nrpt_out_if out_chan ();

  nested_region_peak_tracker uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  region_req_t    queued_reqs[$];
  region_result_t awaited_results[$];

  // predictor state
  nrpt_pkg::sz_t stamp_mem     [nrpt_pkg::MAX_STAMPS];
  nrpt_pkg::sz_t ivl_peak_mem  [nrpt_pkg::MAX_STAMPS];
  longint        ivl_delta_mem [nrpt_pkg::MAX_STAMPS];
  int     n_stamps = 0;
  int     n_ivls   = 0;
  int     n_open   = 0;

  // generator's view: stamp indices of the regions it has left open
  int     gen_stamps = 0;
  int     gen_open_idx[$];
  longint usage_lvl = 0;

  int   tx_idle_pct  = 0;
  int   rx_idle_pct  = 0;
  int   holds_wanted = 0;
  int   holds_done   = 0;
  int   hold_left    = 0;
  logic req_taken    = 1'b0;
  int   quiet_cycles = 0;
  int   mismatches   = 0;

  int n_open_ok   = 0;
  int n_close_ok  = 0;
  int n_full      = 0;
  int n_none_open = 0;
  int n_clipped   = 0;
  int deepest     = 0;

  function automatic void log_interval(nrpt_pkg::sz_t eff, nrpt_pkg::sz_t cur);
    nrpt_pkg::sz_t last;
    last = stamp_mem[n_stamps - 1];
    ivl_peak_mem[n_ivls]  = (eff > last) ? eff - last : '0;
    ivl_delta_mem[n_ivls] = longint'(cur) - longint'(last);
    n_ivls++;
  endfunction

  function automatic region_result_t track_region(logic op, nrpt_pkg::sz_t peak,
                                                  nrpt_pkg::sz_t cur, nrpt_pkg::idx_t start);
    region_result_t res;
    nrpt_pkg::sz_t  eff;
    longint         best;
    longint         sum;
    int             i;
    res = '0;
    eff = (cur > peak) ? cur : peak;
    if (op == nrpt_pkg::OP_OPEN) begin
      if (n_stamps >= nrpt_pkg::MAX_STAMPS ||
          (n_stamps > 0 && n_ivls >= nrpt_pkg::MAX_STAMPS)) begin
        res.error = nrpt_pkg::ERR_FULL;
        n_full++;
        return res;
      end
      n_open++;
      if (n_stamps > 0) log_interval(eff, cur);
      stamp_mem[n_stamps] = eff;
      res.stamp_index = nrpt_pkg::idx_t'(n_stamps);
      res.filler_size = eff - cur;
      n_stamps++;
      if (n_stamps > deepest) deepest = n_stamps;
      n_open_ok++;
      return res;
    end
    if (n_open == 0) begin
      res.error = nrpt_pkg::ERR_NONE_OPN;
      n_none_open++;
      return res;
    end
    if (n_stamps == 0 || n_ivls >= nrpt_pkg::MAX_STAMPS) begin
      res.error = nrpt_pkg::ERR_FULL;
      n_full++;
      return res;
    end
    n_open--;
    log_interval(eff, cur);
    best = 0;
    sum  = 0;
    for (i = int'(start); i < n_ivls; i++) begin
      if (sum + longint'(ivl_peak_mem[i]) > best) best = sum + longint'(ivl_peak_mem[i]);
      sum += ivl_delta_mem[i];
    end
    // last close empties everything, otherwise only the fresh interval goes
    if (n_open == 0) begin
      n_stamps = 0;
      n_ivls   = 0;
    end else begin
      n_ivls--;
    end
    if (best > SIZE_HI) best = SIZE_HI;
    if (sum > SIZE_HI || sum < SIZE_LO) begin
      sum = (sum > SIZE_HI) ? SIZE_HI : SIZE_LO;
      n_clipped++;
    end
    res.region_peak  = nrpt_pkg::sz_t'(best);
    res.region_delta = nrpt_pkg::delta_t'(sum);
    n_close_ok++;
    return res;
  endfunction

  task automatic check_result();
    region_result_t want;
    if (awaited_results.size() == 0) begin
      if (mismatches < 10) $display("%0t: result with no request outstanding", $time);
      mismatches++;
      return;
    end
    want = awaited_results.pop_front();
    if (out_chan.stamp_index !== want.stamp_index || out_chan.filler_size !== want.filler_size ||
        out_chan.region_peak !== want.region_peak ||
        out_chan.region_delta !== want.region_delta || out_chan.error !== want.error) begin
      if (mismatches < 10) begin
        $display("%0t: expected idx %0d fill %0h peak %0h delta %0d err %0d", $time,
                 want.stamp_index, want.filler_size, want.region_peak,
                 $signed(want.region_delta), want.error);
        $display("%0t:   actual idx %0d fill %0h peak %0h delta %0d err %0d", $time,
                 out_chan.stamp_index, out_chan.filler_size, out_chan.region_peak,
                 $signed(out_chan.region_delta), out_chan.error);
      end
      mismatches++;
    end
  endtask

  // results are checked before the same edge's request is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) check_result();
      req_taken <= in_chan.valid && in_chan.ready;
      if (in_chan.valid && in_chan.ready)
        awaited_results.push_back(track_region(in_chan.opcode, in_chan.peak_sample,
                                               in_chan.current_sample, in_chan.start_index));
    end
  end

  always @(negedge clk) begin : drive_requests
    region_req_t req;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || req_taken) begin
      if (queued_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        req = queued_reqs.pop_front();
        in_chan.valid          <= 1'b1;
        in_chan.opcode         <= req.opcode;
        in_chan.peak_sample    <= req.peak;
        in_chan.current_sample <= req.cur;
        in_chan.start_index    <= req.start;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk)
    out_chan.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);

  // long receiver hold-off so the block backs up onto its input
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < holds_wanted) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && !(in_chan.valid && in_chan.ready) && !(out_chan.valid && out_chan.ready))
      quiet_cycles <= quiet_cycles + 1;
    else
      quiet_cycles <= 0;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic nrpt_pkg::sz_t rand_size();
    return nrpt_pkg::sz_t'({$urandom(), $urandom()});
  endfunction

  function automatic nrpt_pkg::idx_t rand_idx();
    return nrpt_pkg::idx_t'($urandom_range(nrpt_pkg::MAX_STAMPS - 1));
  endfunction

  task automatic queue_request(logic op, nrpt_pkg::sz_t pk, nrpt_pkg::sz_t cu,
                               nrpt_pkg::idx_t st);
    queued_reqs.push_back('{opcode: op, peak: pk, cur: cu, start: st});
    if (op == nrpt_pkg::OP_OPEN) begin
      if (gen_stamps < nrpt_pkg::MAX_STAMPS) begin
        gen_open_idx.push_back(gen_stamps);
        gen_stamps++;
      end
    end else if (gen_open_idx.size() != 0) begin
      gen_open_idx.delete(gen_open_idx.size() - 1);
      if (gen_open_idx.size() == 0) gen_stamps = 0;
    end
  endtask

  // mostly a drifting usage level with a peak just above it; some raw and extreme values
  task automatic pick_samples(output nrpt_pkg::sz_t pk, output nrpt_pkg::sz_t cu);
    int r;
    r = $urandom_range(99);
    if (r < 6) begin
      pk = rand_size();
      cu = rand_size();
    end else if (r < 10) begin
      pk = $urandom_range(1) ? SZ_MAX : '0;
      cu = $urandom_range(1) ? SZ_MAX : '0;
    end else begin
      if (r < 13)
        usage_lvl = longint'(rand_size());
      else
        usage_lvl += longint'($urandom_range(2097152)) - 64'sd1048576;
      if (usage_lvl < 0) usage_lvl = 0;
      if (usage_lvl > SIZE_HI) usage_lvl = SIZE_HI;
      cu = nrpt_pkg::sz_t'(usage_lvl);
      if (r < 25)
        pk = (usage_lvl > 1000) ?
             nrpt_pkg::sz_t'(usage_lvl - longint'($urandom_range(1000))) : '0;
      else if (usage_lvl > SIZE_HI - 262144)
        pk = SZ_MAX;
      else
        pk = nrpt_pkg::sz_t'(usage_lvl + longint'($urandom_range(262144)));
    end
  endtask

  task automatic queue_directed();
    // close with nothing open, every field at its top
    queue_request(nrpt_pkg::OP_CLOSE, SZ_MAX, SZ_MAX, nrpt_pkg::idx_t'('1));
    queue_request(nrpt_pkg::OP_OPEN, '0, '0, '0);
    queue_request(nrpt_pkg::OP_OPEN, SZ_MAX, '0, '0);
    // current above peak; peak below the last stamp clamps the interval peak
    queue_request(nrpt_pkg::OP_OPEN, nrpt_pkg::sz_t'(5), nrpt_pkg::sz_t'(10), '0);
    // start beyond the recorded intervals: empty walk
    queue_request(nrpt_pkg::OP_CLOSE, nrpt_pkg::sz_t'(7), nrpt_pkg::sz_t'(3),
                  nrpt_pkg::idx_t'('1));
    queue_request(nrpt_pkg::OP_CLOSE, nrpt_pkg::sz_t'(20), nrpt_pkg::sz_t'(1),
                  nrpt_pkg::idx_t'(1));
    queue_request(nrpt_pkg::OP_CLOSE, nrpt_pkg::sz_t'(8), nrpt_pkg::sz_t'(8), '0);
    queue_request(nrpt_pkg::OP_CLOSE, '0, '0, '0);
    // repeated crashes from the top drive the net change below its floor
    repeat (3) queue_request(nrpt_pkg::OP_OPEN, SZ_MAX, '0, '0);
    queue_request(nrpt_pkg::OP_CLOSE, SZ_MAX, '0, '0);
    queue_request(nrpt_pkg::OP_CLOSE, SZ_MAX, '0, nrpt_pkg::idx_t'(1));
    queue_request(nrpt_pkg::OP_CLOSE, SZ_MAX, '0, '0);
    // peak rise over the whole range
    queue_request(nrpt_pkg::OP_OPEN, '0, '0, '0);
    queue_request(nrpt_pkg::OP_CLOSE, SZ_MAX, SZ_MAX, '0);
    queue_request(nrpt_pkg::OP_OPEN, '0, SZ_MAX, '0);
    queue_request(nrpt_pkg::OP_CLOSE, '0, '0, '0);
  endtask

  // nest until the stamp table is full, push past it, then unwind
  task automatic queue_deep_nest();
    nrpt_pkg::sz_t pk;
    nrpt_pkg::sz_t cu;
    while (gen_stamps < nrpt_pkg::MAX_STAMPS) begin
      pick_samples(pk, cu);
      queue_request(nrpt_pkg::OP_OPEN, pk, cu, rand_idx());
    end
    repeat (2) begin
      pick_samples(pk, cu);
      queue_request(nrpt_pkg::OP_OPEN, pk, cu, rand_idx());
    end
    while (gen_open_idx.size() != 0) begin
      pick_samples(pk, cu);
      queue_request(nrpt_pkg::OP_CLOSE, pk, cu, nrpt_pkg::idx_t'(gen_open_idx[$]));
    end
  endtask

  task automatic queue_random_traffic(int count);
    nrpt_pkg::sz_t  pk;
    nrpt_pkg::sz_t  cu;
    int             r;
    nrpt_pkg::idx_t st;
    repeat (count) begin
      pick_samples(pk, cu);
      r = $urandom_range(99);
      if (r < 4) begin
        queue_request(logic'($urandom_range(1)), pk, cu, rand_idx());
      end else if (gen_open_idx.size() == 0) begin
        if (r < 9) queue_request(nrpt_pkg::OP_CLOSE, pk, cu, rand_idx());
        else queue_request(nrpt_pkg::OP_OPEN, pk, cu, rand_idx());
      end else if (r < 48 && gen_stamps < nrpt_pkg::MAX_STAMPS) begin
        queue_request(nrpt_pkg::OP_OPEN, pk, cu, rand_idx());
      end else begin
        // mostly the region's own start index, now and then a stray one
        st = (r < 92) ? nrpt_pkg::idx_t'(gen_open_idx[$]) : rand_idx();
        queue_request(nrpt_pkg::OP_CLOSE, pk, cu, st);
      end
    end
  endtask

  task automatic wait_reqs_sent();
    while (queued_reqs.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    in_chan.valid          = 1'b0;
    in_chan.opcode         = nrpt_pkg::OP_OPEN;
    in_chan.peak_sample    = '0;
    in_chan.current_sample = '0;
    in_chan.start_index    = '0;
    out_chan.ready         = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    tx_idle_pct = 35;
    rx_idle_pct = 77;
    queue_directed();
    queue_random_traffic(170);
    wait_reqs_sent();

    tx_idle_pct = 77;
    rx_idle_pct = 35;
    queue_deep_nest();
    queue_random_traffic(60);
    wait_reqs_sent();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    @(negedge clk) holds_wanted = 1;
    queue_random_traffic(180);
    wait_reqs_sent();

    while (in_chan.valid || awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $display("%0d results never arrived", awaited_results.size());
      mismatches += awaited_results.size();
    end

    $display("Covered %0d opens, %0d closes, %0d table-full and %0d none-open rejections.",
             n_open_ok, n_close_ok, n_full, n_none_open);
    $display("Deepest stamp table %0d, %0d closes with a clipped net change, %0d mismatches.",
             deepest, n_clipped, mismatches);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
